// ----- hw/rtl/optc_pkg.sv -----
// ----------------------------------------------------------------------------
// Offset point tracking controller package
// Shared types, constants, microprogram and saturation helpers.
// ----------------------------------------------------------------------------
package optc_pkg;

    localparam logic signed [35:0] PI_A       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_A  = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_A   = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
    localparam logic [34:0]        PHASE_WRAP = 35'h6487ED511;
    localparam logic [4:0]         TRIG_LAST  = 5'd17;
    localparam logic [4:0]         DIV_LAST   = 5'd31;
    localparam logic [5:0]         LAST_PC    = 6'd46;

    typedef enum logic [3:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_TRIGP, OP_TRIGB,
        OP_COS, OP_SIN, OP_CLIPV, OP_CLIPW
    } t_op;

    typedef enum logic [4:0] {
        SL_CP, SL_SP, SL_CB, SL_SB, SL_XR, SL_YR, SL_XD, SL_YD, SL_T1, SL_T2,
        SL_XP, SL_YP, SL_EX, SL_EY, SL_RAT, SL_K00, SL_K01, SL_K10, SL_K11,
        SL_DET, SL_I00, SL_I01, SL_I10, SL_I11, SL_UX, SL_UY, SL_V, SL_W
    } t_slot;

    typedef enum logic [2:0] {
        X_PX, X_PY, X_RAD, X_OFS, X_WB, X_GAIN, X_ZERO
    } t_ext;

    typedef enum logic [2:0] {
        CFG_RADIUS, CFG_OFFSET, CFG_WHEELBASE, CFG_GAIN, CFG_STEP, CFG_LIMIT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_START, ST_BUSY, ST_WRITE, ST_DONE
    } t_state;

    typedef struct packed {
        logic  ext;
        t_ext  xsel;
        t_slot slot;
    } t_src;

    typedef struct packed {
        t_op   op;
        t_src  a;
        t_src  b;
        t_slot dst;
    } t_uop;

    typedef struct packed {
        logic cap;
        logic rd;
        logic start;
        logic wr;
        logic load_out;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

    typedef struct packed {
        logic signed [31:0] radius;
        logic [30:0]        offset;
        logic [30:0]        wheelbase;
        logic [30:0]        gain;
        logic [31:0]        step;
        logic [30:0]        limit;
    } t_cfg;

    function automatic t_src ms(input t_slot s);
        t_src r;
        r.ext  = 1'b0;
        r.xsel = X_ZERO;
        r.slot = s;
        return r;
    endfunction

    function automatic t_src xs(input t_ext e);
        t_src r;
        r.ext  = 1'b1;
        r.xsel = e;
        r.slot = SL_CP;
        return r;
    endfunction

    function automatic t_uop mk(input t_op op, input t_src a, input t_src b, input t_slot d);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = d;
        return u;
    endfunction

    function automatic t_uop prog(input logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(OP_TRIGP, xs(X_ZERO), xs(X_ZERO), SL_CP);
            6'd1:  u = mk(OP_COS, xs(X_ZERO), xs(X_ZERO), SL_CP);
            6'd2:  u = mk(OP_SIN, xs(X_ZERO), xs(X_ZERO), SL_SP);
            6'd3:  u = mk(OP_TRIGB, xs(X_ZERO), xs(X_ZERO), SL_CB);
            6'd4:  u = mk(OP_COS, xs(X_ZERO), xs(X_ZERO), SL_CB);
            6'd5:  u = mk(OP_SIN, xs(X_ZERO), xs(X_ZERO), SL_SB);
            6'd6:  u = mk(OP_MUL, xs(X_RAD), ms(SL_CP), SL_XR);
            6'd7:  u = mk(OP_MUL, xs(X_RAD), ms(SL_SP), SL_YR);
            6'd8:  u = mk(OP_MUL, xs(X_RAD), ms(SL_SP), SL_XD);
            6'd9:  u = mk(OP_MUL, xs(X_RAD), ms(SL_CP), SL_YD);
            6'd10: u = mk(OP_MUL, xs(X_OFS), ms(SL_CB), SL_T1);
            6'd11: u = mk(OP_ADD, xs(X_PX), ms(SL_T1), SL_XP);
            6'd12: u = mk(OP_MUL, xs(X_OFS), ms(SL_SB), SL_T1);
            6'd13: u = mk(OP_ADD, xs(X_PY), ms(SL_T1), SL_YP);
            6'd14: u = mk(OP_SUB, ms(SL_XR), ms(SL_XP), SL_EX);
            6'd15: u = mk(OP_SUB, ms(SL_YR), ms(SL_YP), SL_EY);
            6'd16: u = mk(OP_DIV, xs(X_OFS), xs(X_WB), SL_RAT);
            6'd17: u = mk(OP_MUL, ms(SL_RAT), ms(SL_SB), SL_T1);
            6'd18: u = mk(OP_MUL, ms(SL_T1), ms(SL_SB), SL_T1);
            6'd19: u = mk(OP_SUB, ms(SL_CB), ms(SL_T1), SL_K00);
            6'd20: u = mk(OP_MUL, xs(X_OFS), ms(SL_SB), SL_T1);
            6'd21: u = mk(OP_SUB, xs(X_ZERO), ms(SL_T1), SL_K01);
            6'd22: u = mk(OP_MUL, ms(SL_RAT), ms(SL_CB), SL_T1);
            6'd23: u = mk(OP_MUL, ms(SL_T1), ms(SL_SB), SL_T1);
            6'd24: u = mk(OP_ADD, ms(SL_SB), ms(SL_T1), SL_K10);
            6'd25: u = mk(OP_MUL, xs(X_OFS), ms(SL_CB), SL_K11);
            6'd26: u = mk(OP_MUL, ms(SL_K00), ms(SL_K11), SL_T1);
            6'd27: u = mk(OP_MUL, ms(SL_K01), ms(SL_K10), SL_T2);
            6'd28: u = mk(OP_SUB, ms(SL_T1), ms(SL_T2), SL_DET);
            6'd29: u = mk(OP_DIV, ms(SL_K11), ms(SL_DET), SL_I00);
            6'd30: u = mk(OP_SUB, xs(X_ZERO), ms(SL_K01), SL_T1);
            6'd31: u = mk(OP_DIV, ms(SL_T1), ms(SL_DET), SL_I01);
            6'd32: u = mk(OP_SUB, xs(X_ZERO), ms(SL_K10), SL_T1);
            6'd33: u = mk(OP_DIV, ms(SL_T1), ms(SL_DET), SL_I10);
            6'd34: u = mk(OP_DIV, ms(SL_K00), ms(SL_DET), SL_I11);
            6'd35: u = mk(OP_MUL, xs(X_GAIN), ms(SL_EX), SL_T1);
            6'd36: u = mk(OP_ADD, ms(SL_XD), ms(SL_T1), SL_UX);
            6'd37: u = mk(OP_MUL, xs(X_GAIN), ms(SL_EY), SL_T1);
            6'd38: u = mk(OP_ADD, ms(SL_YD), ms(SL_T1), SL_UY);
            6'd39: u = mk(OP_MUL, ms(SL_I00), ms(SL_UX), SL_T1);
            6'd40: u = mk(OP_MUL, ms(SL_I01), ms(SL_UY), SL_T2);
            6'd41: u = mk(OP_ADD, ms(SL_T1), ms(SL_T2), SL_V);
            6'd42: u = mk(OP_MUL, ms(SL_I10), ms(SL_UX), SL_T1);
            6'd43: u = mk(OP_MUL, ms(SL_I11), ms(SL_UY), SL_T2);
            6'd44: u = mk(OP_ADD, ms(SL_T1), ms(SL_T2), SL_W);
            6'd45: u = mk(OP_CLIPV, ms(SL_V), xs(X_ZERO), SL_V);
            default: u = mk(OP_CLIPW, ms(SL_W), xs(X_ZERO), SL_W);
        endcase
        return u;
    endfunction

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if ((&v[47:31]) || !(|v[47:31])) begin
            r = v[31:0];
        end else begin
            r = v[47] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/optc_div.sv -----
// ----------------------------------------------------------------------------
// Fixed point divider
// Rounded signed Q.16 quotient, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module optc_div
    import optc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic signed [31:0] o_quot
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [47:0] r_rem;
    logic [62:0] r_dsh;
    logic [31:0] r_q;
    logic        r_neg;
    logic        r_ovf;

    logic [31:0] abs_n;
    logic [31:0] abs_d;
    logic [47:0] num_r;
    logic        take;
    logic        big;

    always_comb begin
        abs_n = i_num[31] ? 32'(-i_num) : 32'(i_num);
        abs_d = i_den[31] ? 32'(-i_den) : 32'(i_den);
        if (abs_d == 32'd0) begin
            abs_d = 32'd1;
        end
        num_r = {abs_n, 16'b0} + {17'b0, abs_d[31:1]};
        take  = {15'b0, r_rem} >= r_dsh;
        big   = r_ovf | r_q[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[31] ^ i_den[31];
            r_ovf <= {16'b0, num_r} >= {abs_d, 32'b0};
            r_rem <= num_r;
            r_dsh <= {abs_d, 31'b0};
            r_q   <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - r_dsh[47:0];
            end
            r_q   <= {r_q[30:0], take};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = big ? 32'sh80000000 : 32'(-$signed(r_q));
        end else begin
            o_quot = big ? 32'sh7FFFFFFF : $signed(r_q);
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/optc_cordic.sv -----
// ----------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// Rotation mode on Q2.30 angles, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module optc_cordic
    import optc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [35:0] i_angle,
    output logic               o_busy,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic               r_busy;
    logic [4:0]         r_cnt;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic               r_flip;

    logic signed [35:0] a1;
    logic signed [35:0] a2;
    logic               flip;
    logic signed [33:0] step;
    logic signed [33:0] xf;
    logic signed [33:0] yf;
    logic signed [33:0] xr;
    logic signed [33:0] yr;

    always_comb begin
        if (i_angle > PI_A) begin
            a1 = i_angle - TWO_PI_A;
        end else if (i_angle < -PI_A) begin
            a1 = i_angle + TWO_PI_A;
        end else begin
            a1 = i_angle;
        end
        flip = 1'b1;
        if (a1 > HALF_PI_A) begin
            a2 = a1 - PI_A;
        end else if (a1 < -HALF_PI_A) begin
            a2 = a1 + PI_A;
        end else begin
            a2   = a1;
            flip = 1'b0;
        end
        step = $signed({4'b0, atan_q30(r_cnt)});
        xf   = r_flip ? -r_x : r_x;
        yf   = r_flip ? -r_y : r_y;
        xr   = xf + 34'sd8192;
        yr   = yf + 34'sd8192;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == TRIG_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= a2[33:0];
            r_flip <= flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - (r_y >>> r_cnt);
                r_y <= r_y + (r_x >>> r_cnt);
                r_z <= r_z - step;
            end else begin
                r_x <= r_x + (r_y >>> r_cnt);
                r_y <= r_y - (r_x >>> r_cnt);
                r_z <= r_z + step;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = {{12{xr[33]}}, xr[33:14]};
    assign o_sin  = {{12{yr[33]}}, yr[33:14]};

endmodule

// ----- hw/rtl/optc_dp.sv -----
// ----------------------------------------------------------------------------
// Controller datapath
// Operand memory, shared multiplier, adder, divider, CORDIC and clipping.
// ----------------------------------------------------------------------------
module optc_dp
    import optc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [18:0] i_steer_angle,
    output t_sts               o_sts,
    output logic signed [31:0] o_speed_command,
    output logic signed [31:0] o_steer_rate_command,
    output logic               o_speed_clipped,
    output logic               o_rate_clipped
);

    logic signed [31:0] r_mem [0:31];
    logic signed [31:0] r_rda;
    logic signed [31:0] r_rdb;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [18:0] r_steer;
    logic [34:0]        r_phase;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_alu;
    logic signed [31:0] r_v;
    logic signed [31:0] r_w;
    logic               r_vc;
    logic               r_wc;

    t_op                op;
    logic signed [31:0] a_val;
    logic signed [31:0] b_val;
    logic signed [32:0] lim_p;
    logic signed [32:0] lim_n;
    logic signed [32:0] a_ext;
    logic signed [63:0] prod_r;
    logic signed [31:0] wdata;
    logic               we;
    logic [34:0]        ph_sum;
    logic signed [35:0] angle;
    logic               div_start;
    logic               cor_start;
    logic               div_busy;
    logic               cor_busy;
    logic signed [31:0] div_q;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;

    function automatic logic signed [31:0] src_val(input t_src s, input logic signed [31:0] m,
                                                   input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input t_cfg c);
        logic signed [31:0] r;
        if (!s.ext) begin
            r = m;
        end else begin
            unique case (s.xsel)
                X_PX:    r = px;
                X_PY:    r = py;
                X_RAD:   r = c.radius;
                X_OFS:   r = $signed({1'b0, c.offset});
                X_WB:    r = $signed({1'b0, c.wheelbase});
                X_GAIN:  r = $signed({1'b0, c.gain});
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    always_comb begin
        op        = i_cmd.uop.op;
        a_val     = src_val(i_cmd.uop.a, r_rda, r_px, r_py, i_cfg);
        b_val     = src_val(i_cmd.uop.b, r_rdb, r_px, r_py, i_cfg);
        lim_p     = $signed({2'b0, i_cfg.limit});
        lim_n     = -lim_p;
        a_ext     = {a_val[31], a_val};
        prod_r    = r_prod + 64'sd32768;
        ph_sum    = r_phase + {3'b0, i_cfg.step};
        angle     = (op == OP_TRIGP) ? $signed({3'b0, r_phase[34:2]})
                                     : $signed({{3{r_steer[18]}}, r_steer, 14'b0});
        div_start = i_cmd.start && (op == OP_DIV);
        cor_start = i_cmd.start && ((op == OP_TRIGP) || (op == OP_TRIGB));
        we        = i_cmd.wr && (op != OP_TRIGP) && (op != OP_TRIGB)
                    && (op != OP_CLIPV) && (op != OP_CLIPW);
        unique case (op)
            OP_MUL:  wdata = sat48(prod_r[63:16]);
            OP_DIV:  wdata = div_q;
            OP_COS:  wdata = cos_v;
            OP_SIN:  wdata = sin_v;
            default: wdata = r_alu;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[i_cmd.uop.dst] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rda <= r_mem[i_cmd.uop.a.slot];
            r_rdb <= r_mem[i_cmd.uop.b.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_steer <= i_steer_angle;
        end
        if (i_cmd.start) begin
            r_prod <= a_val * b_val;
            if (op == OP_SUB) begin
                r_alu <= sat33(a_ext - {b_val[31], b_val});
            end else begin
                r_alu <= sat33(a_ext + {b_val[31], b_val});
            end
            if (op == OP_CLIPV) begin
                r_v  <= (a_ext > lim_p) ? lim_p[31:0] : (a_ext < lim_n) ? lim_n[31:0] : a_val;
                r_vc <= (a_ext > lim_p) || (a_ext < lim_n);
            end
            if (op == OP_CLIPW) begin
                r_w  <= (a_ext > lim_p) ? lim_p[31:0] : (a_ext < lim_n) ? lim_n[31:0] : a_val;
                r_wc <= (a_ext > lim_p) || (a_ext < lim_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.start && (op == OP_TRIGP)) begin
            r_phase <= (ph_sum > PHASE_WRAP) ? 35'd0 : ph_sum;
        end
    end

    optc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (a_val),
        .i_den   (b_val),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    optc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (angle),
        .o_busy  (cor_busy),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    assign o_sts.busy           = div_busy | cor_busy;
    assign o_speed_command      = r_v;
    assign o_steer_rate_command = r_w;
    assign o_speed_clipped      = r_vc;
    assign o_rate_clipped       = r_wc;

endmodule

// ----- hw/rtl/optc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Controller sequencer
// Steps the datapath through the microprogram once per accepted request.
// ----------------------------------------------------------------------------
module optc_ctrl
    import optc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [5:0] r_pc;
    logic [5:0] n_pc;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                n_pc = '0;
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_START;
            ST_START: n_state = ST_BUSY;
            ST_BUSY: begin
                if (!i_sts.busy) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_pc == LAST_PC) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                    n_pc    = r_pc + 6'd1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.cap      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rd       = (r_state == ST_READ);
        o_cmd.start    = (r_state == ST_START);
        o_cmd.wr       = (r_state == ST_WRITE);
        o_cmd.load_out = (r_state == ST_DONE) && i_out_free;
        o_cmd.uop      = prog(r_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= LAST_PC)
        else $error("program counter beyond the last step");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> !i_sts.busy)
        else $error("result written while a unit is still busy");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && (o_cmd.uop.op == OP_DIV)) |=> i_sts.busy)
        else $error("divider did not start");

    a_done_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_pc == LAST_PC))
        else $error("request finished before the last step");

endmodule

// ----- hw/rtl/offset_point_tracking_controller.sv -----
// ----------------------------------------------------------------------------
// Offset point tracking controller
// Speed and steering rate commands for a bicycle model vehicle.
// ----------------------------------------------------------------------------
// An accepted request runs the microprogram of 47 steps through one shared
// datapath; each step reads its operands, starts its unit, waits while the
// divider or CORDIC is busy and then writes. Among the steps are five divisions
// and two CORDIC runs. One request is handled at a time; the next is taken once
// the result is in the output register.
// Reset (synchronous, active low) restores the register defaults and phase.
// ----------------------------------------------------------------------------
module offset_point_tracking_controller
    import optc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,   // pos_x, pos_y, steer_angle, zero fill
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // speed_command, steer_rate_command
    output logic [1:0]  o_m_axis_tuser,   // speed_clipped, rate_clipped
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_sts  sts;
    logic  r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_user;
    logic  out_free;
    logic signed [31:0] speed;
    logic signed [31:0] rate;
    logic  speed_clip;
    logic  rate_clip;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius    <= -32'sd6553600;
            r_cfg.offset    <= 31'd32768;
            r_cfg.wheelbase <= 31'd91095;
            r_cfg.gain      <= 31'd65536;
            r_cfg.step      <= 32'd42950;
            r_cfg.limit     <= 31'd78643;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS:    r_cfg.radius    <= i_cfg_data;
                CFG_OFFSET:    r_cfg.offset    <= i_cfg_data[30:0];
                CFG_WHEELBASE: r_cfg.wheelbase <= i_cfg_data[30:0];
                CFG_GAIN:      r_cfg.gain      <= i_cfg_data[30:0];
                CFG_STEP:      r_cfg.step      <= i_cfg_data;
                CFG_LIMIT:     r_cfg.limit     <= i_cfg_data[30:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_data <= {rate, speed};
            r_out_user <= {rate_clip, speed_clip};
        end
    end

    optc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    optc_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_cmd                (cmd),
        .i_pos_x              (i_s_axis_tdata[31:0]),
        .i_pos_y              (i_s_axis_tdata[63:32]),
        .i_steer_angle        (i_s_axis_tdata[82:64]),
        .o_sts                (sts),
        .o_speed_command      (speed),
        .o_steer_rate_command (rate),
        .o_speed_clipped      (speed_clip),
        .o_rate_clipped       (rate_clip)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
